FILE: hw/rtl/tscw_pkg.sv
// ----------------------------------------------------------------------------
// tscw_pkg: shared types and constants for the coincidence window builder
// Payload structs, result action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tscw_pkg;

   localparam int STAMP_W     = 48;
   localparam int IDX_W       = 10;
   localparam int WIDTH_W     = 16;
   localparam int CUTOFF_W    = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CUTOFF_W-1:0] CUTOFF_CAP  = 5'd20;
   localparam int                  QUEUE_DEPTH = 22;
   localparam int                  QCOUNT_W    = 5;
   localparam int                  RCOUNT_W    = 7;
   localparam logic [7:0]          MAX_RESULTS = 8'd64;

   localparam logic [1:0] ACT_PRESORT_CLOSE = 2'd0;
   localparam logic [1:0] ACT_SORT_ONE      = 2'd1;
   localparam logic [1:0] ACT_SKIP          = 2'd2;
   localparam logic [1:0] ACT_ADD           = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_PRESORT_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SORT_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT_CUTOFF  = 2'd2;

   localparam logic [WIDTH_W-1:0]  PRESORT_WIDTH_RESET = 16'd500;
   localparam logic [WIDTH_W-1:0]  SORT_WIDTH_RESET    = 16'd200;
   localparam logic [CUTOFF_W-1:0] COUNT_CUTOFF_RESET  = 5'd20;

   typedef struct packed {
      logic [STAMP_W-1:0] timestamp;
      logic               has_channel;
   } req_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
      logic             last;
   } rsp_type;

   // one stored fragment
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic               mapped;
   } frag_type;

endpackage

FILE: hw/rtl/two_stage_coincidence_window.sv
// ----------------------------------------------------------------------------
// two_stage_coincidence_window: two-stage sliding coincidence window builder
// Stores fragments in a ring and emits presort-close, sort-one, skip and add
// range commands as entries slide through the presort and sort windows.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one fragment (timestamp, has_channel); it transfers when
//    req_valid is high and req_stall low. req_stall stays high while an
//    item is being worked on: one item at a time.
//  - rsp_* carries the range commands of the item, 0 to 64 of them, the
//    final one flagged by last. rsp_stall holds the output register; the
//    sequencer waits while both its pending and output registers are full.
//  - csr_* writes presort_width (0), sort_width (1), count_cutoff (2);
//    csr_ready is always high. Write only while the block is idle.
//  - Steps: accept, then each presort check, each sort window step
//    (eviction or add) and the last result, in that order. The sort window
//    queue steps one entry per cycle while the output does not stall, and
//    bounds the rate.
//  - The first result goes through the pending and then the output register.
//  - Synchronous reset empties both windows and restores register defaults;
//    the ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module two_stage_coincidence_window #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tscw_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tscw_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tscw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tscw_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
   localparam int QN = tscw_pkg::QUEUE_DEPTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PCHK = 2'd1;
   localparam logic [1:0] ST_SORT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      return (i == LAST_SLOT) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
      return (i == '0) ? LAST_SLOT : i - AW'(1);
   endfunction

   function automatic logic [tscw_pkg::IDX_W-1:0] to_idx(input logic [AW-1:0] i);
      logic [AW+tscw_pkg::IDX_W-1:0] w;
      w = (AW + tscw_pkg::IDX_W)'(i);
      return w[tscw_pkg::IDX_W-1:0];
   endfunction

   function automatic logic [tscw_pkg::STAMP_W-1:0] abs_diff(
      input logic [tscw_pkg::STAMP_W-1:0] a,
      input logic [tscw_pkg::STAMP_W-1:0] b
   );
      return (a >= b) ? a - b : b - a;
   endfunction

   // registers
   logic [1:0]                           state_ff, state_in;
   logic [AW-1:0]                        wi_ff, wi_in;
   logic [AW-1:0]                        ps_ff, ps_in;
   logic [AW-1:0]                        ss_ff, ss_in;
   logic [AW-1:0]                        slot_ff, slot_in;
   logic [tscw_pkg::STAMP_W-1:0]         new_stamp_ff, new_stamp_in;
   tscw_pkg::frag_type                   p_frag_ff, p_frag_in;
   logic [tscw_pkg::QCOUNT_W-1:0]        q_ff, q_in;
   logic [tscw_pkg::RCOUNT_W-1:0]        n_ff, n_in;
   logic                                 pend_valid_ff, pend_valid_in;
   tscw_pkg::rsp_type                    pend_ff, pend_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   tscw_pkg::rsp_type                    rsp_data_ff, rsp_data_in;
   logic [tscw_pkg::WIDTH_W-1:0]         pw_ff, pw_in;
   logic [tscw_pkg::WIDTH_W-1:0]         sw_ff, sw_in;
   logic [tscw_pkg::CUTOFF_W-1:0]        cutoff_ff, cutoff_in;

   // datapath
   logic                                 out_free;
   logic                                 go;
   logic                                 emit;
   tscw_pkg::rsp_type                    emit_data;
   logic                                 move;
   logic                                 finish;
   logic [tscw_pkg::CUTOFF_W-1:0]        cut;
   logic [AW-1:0]                        pcnt;
   logic                                 p_keep;
   logic                                 fits;
   logic                                 s_keep;
   logic                                 push;
   logic                                 pop;
   logic                                 mem_we;
   tscw_pkg::frag_type                   mem_wdata;
   tscw_pkg::frag_type                   rd_frag;
   tscw_pkg::frag_type                   cell_data [QN];
   tscw_pkg::frag_type                   cell_next [QN];

   tscw_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wi_ff),
      .wr_data (mem_wdata),
      .rd_addr (ps_in),
      .rd_data (rd_frag)
   );

   // sort window: entries sort_start .. presort_start-1, oldest in cell 0
   for (genvar g = 0; g < QN; g++) begin : g_cell
      if (g == QN - 1) begin : g_tail
         assign cell_next[g] = '0;
      end else begin : g_mid
         assign cell_next[g] = cell_data[g+1];
      end
      tscw_cell u_cell (
         .clock     (clock),
         .shift     (pop),
         .load      (push && (q_ff == tscw_pkg::QCOUNT_W'(g))),
         .neighbor  (cell_next[g]),
         .load_data (p_frag_ff),
         .data      (cell_data[g])
      );
   end

   assign mem_wdata.stamp  = req_data.timestamp;
   assign mem_wdata.mapped = req_data.has_channel;

   assign cut = (cutoff_ff > tscw_pkg::CUTOFF_CAP) ? tscw_pkg::CUTOFF_CAP : cutoff_ff;
   assign pcnt = (slot_ff >= ps_ff) ? slot_ff - ps_ff : slot_ff + AW'(RING_DEPTH) - ps_ff;
   assign p_keep = (abs_diff(new_stamp_ff, rd_frag.stamp)
                      < tscw_pkg::STAMP_W'(pw_ff)) && (pcnt < AW'(cut));
   assign fits = (8'(n_ff) + 8'(q_ff) + 8'd2) <= tscw_pkg::MAX_RESULTS;
   assign s_keep = (abs_diff(p_frag_ff.stamp, cell_data[0].stamp)
                      < tscw_pkg::STAMP_W'(sw_ff)) && (q_ff <= cut);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go = !pend_valid_ff || out_free;

   always_comb begin
      state_in     = state_ff;
      wi_in        = wi_ff;
      ps_in        = ps_ff;
      ss_in        = ss_ff;
      slot_in      = slot_ff;
      new_stamp_in = new_stamp_ff;
      p_frag_in    = p_frag_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      mem_we       = 1'b0;
      emit         = 1'b0;
      emit_data    = '0;
      finish       = 1'b0;
      push         = 1'b0;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mem_we       = 1'b1;
               slot_in      = wi_ff;
               new_stamp_in = req_data.timestamp;
               wi_in        = ring_next(wi_ff);
               n_in         = '0;
               state_in     = (ps_ff == wi_ff) ? ST_DONE : ST_PCHK;
            end
         end
         ST_PCHK: begin
            if (go) begin
               if (p_keep || !fits) begin
                  state_in = ST_DONE;
               end else begin
                  emit                  = 1'b1;
                  emit_data.action      = tscw_pkg::ACT_PRESORT_CLOSE;
                  emit_data.first_index = to_idx(ps_ff);
                  emit_data.last_index  = to_idx(ring_prev(slot_ff));
                  n_in                  = n_ff + tscw_pkg::RCOUNT_W'(1);
                  p_frag_in             = rd_frag;
                  state_in              = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (go) begin
               if (q_ff == '0 || s_keep) begin
                  if (q_ff != '0) begin
                     emit                  = 1'b1;
                     emit_data.action      = tscw_pkg::ACT_ADD;
                     emit_data.first_index = to_idx(ss_ff);
                     emit_data.last_index  = to_idx(ps_ff);
                     n_in                  = n_ff + tscw_pkg::RCOUNT_W'(1);
                  end
                  // departing entry joins the sort window
                  push     = 1'b1;
                  q_in     = q_ff + tscw_pkg::QCOUNT_W'(1);
                  ps_in    = ring_next(ps_ff);
                  state_in = (ring_next(ps_ff) == slot_ff) ? ST_DONE : ST_PCHK;
               end else begin
                  emit                  = 1'b1;
                  emit_data.action      = cell_data[0].mapped ? tscw_pkg::ACT_SORT_ONE
                                                              : tscw_pkg::ACT_SKIP;
                  emit_data.first_index = to_idx(ss_ff);
                  emit_data.last_index  = to_idx(ring_prev(ps_ff));
                  n_in                  = n_ff + tscw_pkg::RCOUNT_W'(1);
                  pop                   = 1'b1;
                  q_in                  = q_ff - tscw_pkg::QCOUNT_W'(1);
                  ss_in                 = ring_next(ss_ff);
               end
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pending result moves to the output once its successor or the end is known
   assign move = pend_valid_ff && out_free && (emit || finish);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = pend_ff;
         rsp_data_in.last = finish;
      end
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_in       = emit_data;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      pw_in     = pw_ff;
      sw_in     = sw_ff;
      cutoff_in = cutoff_ff;
      if (csr_valid) begin
         case (csr_index)
            tscw_pkg::REG_PRESORT_WIDTH: pw_in = csr_data;
            tscw_pkg::REG_SORT_WIDTH:    sw_in = csr_data;
            tscw_pkg::REG_COUNT_CUTOFF:  cutoff_in = csr_data[tscw_pkg::CUTOFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wi_ff         <= '0;
         ps_ff         <= '0;
         ss_ff         <= '0;
         q_ff          <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pw_ff         <= tscw_pkg::PRESORT_WIDTH_RESET;
         sw_ff         <= tscw_pkg::SORT_WIDTH_RESET;
         cutoff_ff     <= tscw_pkg::COUNT_CUTOFF_RESET;
      end else begin
         state_ff      <= state_in;
         wi_ff         <= wi_in;
         ps_ff         <= ps_in;
         ss_ff         <= ss_in;
         q_ff          <= q_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pw_ff         <= pw_in;
         sw_ff         <= sw_in;
         cutoff_ff     <= cutoff_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      new_stamp_ff <= new_stamp_in;
      p_frag_ff    <= p_frag_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_ff < tscw_pkg::QCOUNT_W'(QN))
      else $error("sort window queue overflow");

   a_result_budget: assert property (@(posedge clock) disable iff (reset)
      8'(n_ff) <= tscw_pkg::MAX_RESULTS)
      else $error("result budget exceeded");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind at idle");

endmodule

FILE: hw/rtl/tscw_ring.sv
// ----------------------------------------------------------------------------
// tscw_ring: fragment ring memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tscw_ring #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  tscw_pkg::frag_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output tscw_pkg::frag_type rd_data
);

   tscw_pkg::frag_type mem [DEPTH];
   tscw_pkg::frag_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

FILE: hw/rtl/tscw_cell.sv
// ----------------------------------------------------------------------------
// tscw_cell: one slot of the sort window queue
// Takes its right neighbor's fragment on a pop, or a new fragment on a push.
// ----------------------------------------------------------------------------
module tscw_cell (
   input  logic               clock,
   input  logic               shift,
   input  logic               load,
   input  tscw_pkg::frag_type neighbor,
   input  tscw_pkg::frag_type load_data,
   output tscw_pkg::frag_type data
);

   tscw_pkg::frag_type data_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= neighbor;
      end else if (load) begin
         data_ff <= load_data;
      end
   end

   assign data = data_ff;

endmodule

FILE: tb/tb_two_stage_coincidence_window.sv
// ----------------------------------------------------------------------------
// tb_two_stage_coincidence_window: self-checking bench for the window builder
// Drives fragments through a short directed table and then random phases under
// several register settings. A behavioral copy of both windows predicts each
// range command, and every transfer on rsp_* is checked field by field.
// ----------------------------------------------------------------------------
module tb_two_stage_coincidence_window;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 1024;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   tscw_pkg::req_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   tscw_pkg::rsp_type rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [tscw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tscw_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   two_stage_coincidence_window u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // window mirror
   logic [tscw_pkg::STAMP_W-1:0] stamp_mem [DEPTH];
   bit                 mapped_mem [DEPTH];
   int unsigned        wr_ptr = 0, presort_head = 0, sort_head = 0;
   int unsigned        presort_w = tscw_pkg::PRESORT_WIDTH_RESET;
   int unsigned        sort_w = tscw_pkg::SORT_WIDTH_RESET;
   int unsigned        cutoff_raw = tscw_pkg::COUNT_CUTOFF_RESET;

   tscw_pkg::rsp_type range_cmds[$];     // commands caused by the current fragment
   tscw_pkg::rsp_type pending_cmds[$];   // commands still to arrive
   int          errors = 0;
   bit          quiet = 0;
   bit          hold_go = 0;

   function automatic int unsigned ring_nxt(int unsigned i);
      return (i == DEPTH - 1) ? 0 : i + 1;
   endfunction

   function automatic int unsigned ring_prv(int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   function automatic int unsigned ring_span(int unsigned to, int unsigned from);
      return (to + DEPTH - from) % DEPTH;
   endfunction

   function automatic logic [tscw_pkg::STAMP_W-1:0] stamp_gap(
      logic [tscw_pkg::STAMP_W-1:0] a,
      logic [tscw_pkg::STAMP_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic int unsigned cutoff_eff();
      return (cutoff_raw > tscw_pkg::CUTOFF_CAP) ? tscw_pkg::CUTOFF_CAP : cutoff_raw;
   endfunction

   function automatic void push_cmd(logic [1:0] act, int unsigned first, int unsigned lst);
      tscw_pkg::rsp_type c;
      c.action      = act;
      c.first_index = first[tscw_pkg::IDX_W-1:0];
      c.last_index  = lst[tscw_pkg::IDX_W-1:0];
      c.last        = 1'b0;
      range_cmds.push_back(c);
   endfunction

   // entry p leaves presort and joins the sort window
   function automatic void sort_join(int unsigned p);
      int unsigned cut, stop;
      cut  = cutoff_eff();
      stop = ring_prv(p);
      while (sort_head != p) begin
         if (stamp_gap(stamp_mem[p], stamp_mem[sort_head]) < sort_w &&
             ring_span(p, sort_head) <= cut) begin
            push_cmd(tscw_pkg::ACT_ADD, sort_head, p);
            return;
         end
         push_cmd(mapped_mem[sort_head] ? tscw_pkg::ACT_SORT_ONE : tscw_pkg::ACT_SKIP,
                  sort_head, stop);
         sort_head = ring_nxt(sort_head);
      end
   endfunction

   function automatic void predict_ranges(tscw_pkg::req_type r);
      int unsigned slot, cut, stop, need;
      slot = wr_ptr;
      cut  = cutoff_eff();
      stop = ring_prv(slot);
      range_cmds.delete();
      stamp_mem[slot]  = r.timestamp;
      mapped_mem[slot] = r.has_channel;
      while (presort_head != slot) begin
         if (stamp_gap(stamp_mem[slot], stamp_mem[presort_head]) < presort_w &&
             ring_span(slot, presort_head) < cut)
            break;
         need = ring_span(presort_head, sort_head) + 2;
         // hold the rest of the departures for the next fragment
         if (range_cmds.size() + need > tscw_pkg::MAX_RESULTS) break;
         push_cmd(tscw_pkg::ACT_PRESORT_CLOSE, presort_head, stop);
         sort_join(presort_head);
         presort_head = ring_nxt(presort_head);
      end
      wr_ptr = ring_nxt(slot);
      if (range_cmds.size() > 0) range_cmds[range_cmds.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
   endtask

   always @(negedge clock) begin
      tscw_pkg::rsp_type exp_cmd;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            exp_cmd = pending_cmds.pop_front();
            if (rsp_data.action !== exp_cmd.action)
               report_mismatch($sformatf("action %0d, expected %0d",
                                         rsp_data.action, exp_cmd.action));
            if (rsp_data.first_index !== exp_cmd.first_index)
               report_mismatch($sformatf("first_index %0d, expected %0d",
                                         rsp_data.first_index, exp_cmd.first_index));
            if (rsp_data.last_index !== exp_cmd.last_index)
               report_mismatch($sformatf("last_index %0d, expected %0d",
                                         rsp_data.last_index, exp_cmd.last_index));
            if (rsp_data.last !== exp_cmd.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_data.last, exp_cmd.last));
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_go) begin
            hold_go   = 0;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 8);
         end
      end
   end

   task automatic send_fragment(tscw_pkg::req_type r, bit fixed, bit fix_has,
                                tscw_pkg::rsp_type fix_cmd);
      bit taken;
      if (!quiet && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_ranges(r);
      if (fixed) begin
         range_cmds.delete();
         if (fix_has) range_cmds.push_back(fix_cmd);
      end
      foreach (range_cmds[i]) pending_cmds.push_back(range_cmds[i]);
   endtask

   // drop valid and wait until the block has nothing left in flight
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(logic [tscw_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tscw_pkg::CSR_DATA_W-1:0] val);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      case (idx)
         tscw_pkg::REG_PRESORT_WIDTH: presort_w  = val;
         tscw_pkg::REG_SORT_WIDTH:    sort_w     = val;
         tscw_pkg::REG_COUNT_CUTOFF:  cutoff_raw = val[tscw_pkg::CUTOFF_W-1:0];
         default: ;
      endcase
   endtask

   typedef struct {
      logic [tscw_pkg::STAMP_W-1:0] stamp;
      bit                 mapped;
      bit                 fixed;
      bit                 fix_has;
      tscw_pkg::rsp_type  fix_cmd;
   } frag_row_type;

   localparam tscw_pkg::rsp_type NO_CMD = '0;

   frag_row_type directed [] = '{
      '{48'd0,             1, 1, 0, NO_CMD},   // first fragment: nothing to close
      '{48'd1000,          1, 1, 1, '{tscw_pkg::ACT_PRESORT_CLOSE, 10'd0, 10'd0, 1'b1}},
      '{48'd1100,          0, 0, 0, NO_CMD},
      '{48'd1150,          0, 0, 0, NO_CMD},
      '{48'd1300,          1, 0, 0, NO_CMD},
      '{48'd1700,          1, 0, 0, NO_CMD},
      '{48'd2400,          0, 0, 0, NO_CMD},
      '{48'd2401,          1, 0, 0, NO_CMD},
      '{48'hFFFF_FFFF_FFFF, 1, 0, 0, NO_CMD},  // jump to the top empties the presort window
      '{48'hFFFF_FFFF_FFF0, 0, 0, 0, NO_CMD},  // step backwards
      '{48'hFFFF_FFFF_FE00, 1, 0, 0, NO_CMD},
      '{48'd0,             1, 0, 0, NO_CMD},   // back to zero
      '{48'd0,             0, 0, 0, NO_CMD},
      '{48'd199,           1, 0, 0, NO_CMD},
      '{48'd200,           1, 0, 0, NO_CMD},
      '{48'd499,           0, 0, 0, NO_CMD},
      '{48'd500,           1, 0, 0, NO_CMD},
      '{48'h5555_5555_5555, 1, 0, 0, NO_CMD},
      '{48'hAAAA_AAAA_AAAA, 0, 0, 0, NO_CMD}
   };

   // presort width, sort width, count cutoff
   int unsigned settings [7][3] = '{
      '{500, 200, 20}, '{65535, 65535, 31}, '{1, 65535, 20}, '{0, 0, 0},
      '{65535, 1, 1}, '{30, 10, 3}, '{2000, 700, 12}
   };

   initial begin
      tscw_pkg::req_type            frag;
      logic [tscw_pkg::STAMP_W-1:0] now_ts;
      logic [63:0]                  rnd;
      int unsigned        scale, pick, pw, sw, ct;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         frag.timestamp   = directed[i].stamp;
         frag.has_channel = directed[i].mapped;
         send_fragment(frag, directed[i].fixed, directed[i].fix_has, directed[i].fix_cmd);
      end
      drain();

      now_ts = 48'd1000;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 7) begin
            pw = settings[ph][0]; sw = settings[ph][1]; ct = settings[ph][2];
         end else begin
            pw = $urandom_range(1, 65535); sw = $urandom_range(1, 65535);
            ct = $urandom_range(1, 20);
         end
         csr_write(tscw_pkg::REG_PRESORT_WIDTH, tscw_pkg::CSR_DATA_W'(pw));
         csr_write(tscw_pkg::REG_SORT_WIDTH, tscw_pkg::CSR_DATA_W'(sw));
         csr_write(tscw_pkg::REG_COUNT_CUTOFF, tscw_pkg::CSR_DATA_W'(ct));
         quiet = (ph == 1);
         scale = pw / 3 + 1;
         for (int n = 0; n < 44; n++) begin
            if (ph == 2 && n == 10) hold_go = 1;
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               now_ts += tscw_pkg::STAMP_W'($urandom_range(0, scale));
            end else if (pick < 90) begin
               now_ts += tscw_pkg::STAMP_W'($urandom_range(0, 4 * (pw + sw) + 10));
            end else if (pick < 95) begin
               rnd    = {$urandom, $urandom};
               now_ts = rnd[tscw_pkg::STAMP_W-1:0];
            end else begin
               now_ts -= tscw_pkg::STAMP_W'($urandom_range(0, scale));
            end
            frag.timestamp   = now_ts;
            frag.has_channel = ($urandom_range(0, 3) != 0);
            send_fragment(frag, 0, 0, NO_CMD);
         end
         drain();
      end

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
